>>> design/tea_block_cipher_macros.svh
// Assertion macros of the TEA block cipher design, included by tea_out_queue.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef TEA_BLOCK_CIPHER_MACROS_SVH
`define TEA_BLOCK_CIPHER_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define TEA_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset.
`define TEA_CHECK_NEVER(lbl, cond, msg) \
	`TEA_CHECK(lbl, !(cond), msg)

`endif

>>> design/tea_pkg.sv
// Shared types, constants and round functions of the TEA block cipher.
// No dependencies; every design module imports this package.
`default_nettype none

package tea_pkg;

	localparam int TEA_ROUNDS = 32;
	localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;
	localparam int CFG_INDEX_W = 8;
	localparam int OUT_DEPTH = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEY_WORD0 = 8'd0,
		REG_KEY_WORD1 = 8'd1,
		REG_KEY_WORD2 = 8'd2,
		REG_KEY_WORD3 = 8'd3
	} reg_index_t;

	typedef struct packed {
		logic        action;
		logic [31:0] block_first_word;
		logic [31:0] block_second_word;
	} req_t;

	typedef struct packed {
		logic [31:0] out_first_word;
		logic [31:0] out_second_word;
	} rsp_t;

	typedef struct packed {
		logic [31:0] key_word0;
		logic [31:0] key_word1;
		logic [31:0] key_word2;
		logic [31:0] key_word3;
	} key_t;

	// One word in flight between half-round stages.
	typedef struct packed {
		logic        valid;
		logic        action;
		logic [31:0] w0;
		logic [31:0] w1;
	} stage_t;

	// Running sum after n additions of delta, mod 2^32.
	function automatic logic [31:0] delta_mul(input int n);
		logic [63:0] p;
		p = 64'(TEA_DELTA) * 64'(n);
		return p[31:0];
	endfunction

	function automatic logic [31:0] mix_term(input logic [31:0] w, input logic [31:0] acc,
		input logic [31:0] ka, input logic [31:0] kb);
		return ((w << 4) + ka) ^ (w + acc) ^ ((w >> 5) + kb);
	endfunction

endpackage

`default_nettype wire

>>> design/tea_half_round.sv
// One half-round stage of the TEA pipeline: one word update and its register.
// Depends on tea_pkg for the stage and key types and the mix function.
`default_nettype none

module tea_half_round #(
	parameter int ROUNDS = tea_pkg::TEA_ROUNDS,
	parameter int STAGE  = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire tea_pkg::key_t   key,
	input  wire tea_pkg::stage_t prev,
	output tea_pkg::stage_t      next
);
	import tea_pkg::*;

	localparam int ROUND = STAGE / 2;
	localparam bit ODD = (STAGE % 2) == 1;
	localparam logic [31:0] ENC_SUM = delta_mul(ROUND + 1);
	localparam logic [31:0] DEC_SUM = delta_mul(ROUNDS - ROUND);

	logic        upd_w0;
	logic [31:0] sum;
	logic [31:0] src;
	logic [31:0] dst;
	logic [31:0] ka;
	logic [31:0] kb;
	logic [31:0] term;
	logic [31:0] res;

	logic        valid_s1;
	logic        action_s1;
	logic [31:0] w0_s1;
	logic [31:0] w1_s1;

	// Encrypt updates w0 first in a round; decrypt runs the halves backward.
	always_comb begin
		upd_w0 = (prev.action == ODD);
		sum    = prev.action ? DEC_SUM : ENC_SUM;
		src    = upd_w0 ? prev.w1 : prev.w0;
		dst    = upd_w0 ? prev.w0 : prev.w1;
		ka     = upd_w0 ? key.key_word0 : key.key_word2;
		kb     = upd_w0 ? key.key_word1 : key.key_word3;
		term   = mix_term(src, sum, ka, kb);
		res    = prev.action ? (dst - term) : (dst + term);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			action_s1 <= prev.action;
			w0_s1     <= upd_w0 ? res : prev.w0;
			w1_s1     <= upd_w0 ? prev.w1 : res;
		end
	end

	assign next = '{valid: valid_s1, action: action_s1, w0: w0_s1, w1: w1_s1};

endmodule

`default_nettype wire

>>> design/tea_out_queue.sv
// Two-entry output queue that parts the cipher pipeline from the result channel.
// Depends on tea_pkg for the result word type and queue depth.
`default_nettype none

module tea_out_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire tea_pkg::rsp_t push_data,
	output logic               full,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output tea_pkg::rsp_t      rsp
);
	import tea_pkg::*;

	`include "tea_block_cipher_macros.svh"

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	rsp_t             mem [OUT_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign full      = (count_q == CNT_W'(OUT_DEPTH));
	assign rsp_valid = (count_q != '0);
	assign pop       = rsp_valid && rsp_ready;
	assign rsp       = mem[rd_q];

	// Pointers wrap on their own: depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

	`TEA_CHECK_NEVER(a_count_range, count_q > CNT_W'(OUT_DEPTH), "output queue overfilled")
	`TEA_CHECK_NEVER(a_push_full, push && full, "word pushed into full output queue")
	`TEA_CHECK(a_count_up, push && !pop |=> count_q == $past(count_q) + 1'b1,
		"output queue count missed a push")

endmodule

`default_nettype wire

>>> design/tea_block_cipher.sv
// TEA block cipher engine: takes one 64-bit block per cycle while the output queue is
// not full, encrypts or decrypts it under the 128-bit key held in four configuration
// registers, and returns one result word per block. The rounds are unrolled into
// 2*ROUNDS register stages, one word update (one mix term and one add or subtract) per
// stage, and a new block is taken every cycle while that queue is not full. A two-entry
// output queue holds finished words; the whole pipeline holds in place only while that
// queue is full. Key writes take effect on blocks taken afterward and must not be made
// with blocks in flight.
// Depends on tea_pkg, tea_half_round and tea_out_queue.
`default_nettype none

module tea_block_cipher #(
	parameter int ROUNDS = tea_pkg::TEA_ROUNDS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_ready,
	input  wire tea_pkg::req_t                   req,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_ready,
	output tea_pkg::rsp_t                        rsp,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]                     cfg_data
);
	import tea_pkg::*;

	localparam int STAGES = 2 * ROUNDS;

	key_t   key_q;
	stage_t stg [STAGES+1];
	logic   en;
	logic   full;
	logic   push;
	rsp_t   push_data;

	assign cfg_ready = 1'b1;

	// Unknown indexes drop the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KEY_WORD0: key_q.key_word0 <= cfg_data;
				REG_KEY_WORD1: key_q.key_word1 <= cfg_data;
				REG_KEY_WORD2: key_q.key_word2 <= cfg_data;
				REG_KEY_WORD3: key_q.key_word3 <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en        = !full;
	assign req_ready = en;
	assign stg[0]    = '{valid: req_valid, action: req.action,
		w0: req.block_first_word, w1: req.block_second_word};

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		tea_half_round #(
			.ROUNDS(ROUNDS),
			.STAGE (k)
		) u_half (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.key   (key_q),
			.prev  (stg[k]),
			.next  (stg[k+1])
		);
	end

	assign push      = en && stg[STAGES].valid;
	assign push_data = '{out_first_word: stg[STAGES].w0, out_second_word: stg[STAGES].w1};

	tea_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

>>> verif/tea_block_cipher_checker.sv
// Checker for the TEA block cipher: tracks the key registers, predicts every block
// taken on the request channel and compares each response word against it.
// Depends on tea_pkg for the channel payload types, key layout and cipher constants.
`default_nettype none

module tea_block_cipher_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	input  wire logic                            req_ready,
	input  wire tea_pkg::req_t                   req,
	input  wire logic                            rsp_valid,
	input  wire logic                            rsp_ready,
	input  wire tea_pkg::rsp_t                   rsp,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]                     cfg_data,
	output int                                   mismatches,
	output int                                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import tea_pkg::*;

	key_t cipher_key;
	rsp_t ciphertext_queue [$];

	function automatic logic [31:0] feistel_mix(input logic [31:0] w, input logic [31:0] sum,
		input logic [31:0] ka, input logic [31:0] kb);
		return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
	endfunction

	function automatic rsp_t tea_transform(input req_t blk, input key_t k);
		logic [31:0] v0;
		logic [31:0] v1;
		logic [31:0] sum;
		rsp_t res;
		v0 = blk.block_first_word;
		v1 = blk.block_second_word;
		if (blk.action) begin
			// run the rounds backward from the final sum
			sum = TEA_DELTA * TEA_ROUNDS;
			for (int r = 0; r < TEA_ROUNDS; r++) begin
				v1 -= feistel_mix(v0, sum, k.key_word2, k.key_word3);
				v0 -= feistel_mix(v1, sum, k.key_word0, k.key_word1);
				sum -= TEA_DELTA;
			end
		end else begin
			sum = '0;
			for (int r = 0; r < TEA_ROUNDS; r++) begin
				sum += TEA_DELTA;
				v0 += feistel_mix(v1, sum, k.key_word0, k.key_word1);
				v1 += feistel_mix(v0, sum, k.key_word2, k.key_word3);
			end
		end
		res.out_first_word = v0;
		res.out_second_word = v1;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			cipher_key = '0;
			ciphertext_queue.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (ciphertext_queue.size() == 0) begin
					report_mismatch("response word with nothing pending", rsp.out_first_word, '0);
				end else begin
					want = ciphertext_queue.pop_front();
					if (rsp.out_first_word !== want.out_first_word)
						report_mismatch("out_first_word", rsp.out_first_word, want.out_first_word);
					if (rsp.out_second_word !== want.out_second_word)
						report_mismatch("out_second_word", rsp.out_second_word, want.out_second_word);
				end
			end
			// a block taken on the same edge as a key write still sees the old key
			if (req_valid && req_ready)
				ciphertext_queue.push_back(tea_transform(req, cipher_key));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEY_WORD0: cipher_key.key_word0 = cfg_data;
					REG_KEY_WORD1: cipher_key.key_word1 = cfg_data;
					REG_KEY_WORD2: cipher_key.key_word2 = cfg_data;
					REG_KEY_WORD3: cipher_key.key_word3 = cfg_data;
					default: ;
				endcase
			end
			outstanding <= ciphertext_queue.size();
		end
	end

endmodule

`default_nettype wire

>>> verif/tea_block_cipher_tb.sv
// Top of the TEA block cipher testbench: clock, reset, key programming and block
// stimulus with random idling on both channels; the verdict comes from the checker.
// Depends on tea_pkg, tea_block_cipher and tea_block_cipher_checker.
`default_nettype none

module tea_block_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tea_pkg::*;

	localparam logic ACT_ENCRYPT = 1'b0;
	localparam logic ACT_DECRYPT = 1'b1;
	localparam logic [CFG_INDEX_W-1:0] UNMAPPED_INDEX_LOW = 8'd4;
	localparam logic [CFG_INDEX_W-1:0] UNMAPPED_INDEX_TOP = 8'hff;
	localparam int RANDOM_PHASES = 6;
	localparam int BLOCKS_PER_PHASE = 180;
	localparam int DRAIN_CYCLES = 2 * TEA_ROUNDS + 8;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   req_valid = 1'b0;
	logic                   req_ready;
	req_t                   req = '0;
	logic                   rsp_valid;
	logic                   rsp_ready = 1'b0;
	rsp_t                   rsp;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [31:0]            cfg_data = '0;
	int                     mismatches;
	int                     outstanding;
	logic                   quiet = 1'b0;

	req_t corner_blocks [10] = '{
		'{ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000},
		'{ACT_DECRYPT, 32'h0000_0000, 32'h0000_0000},
		'{ACT_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff},
		'{ACT_DECRYPT, 32'hffff_ffff, 32'hffff_ffff},
		'{ACT_ENCRYPT, 32'h0000_0000, 32'hffff_ffff},
		'{ACT_DECRYPT, 32'hffff_ffff, 32'h0000_0000},
		'{ACT_ENCRYPT, 32'h8000_0000, 32'h0000_0001},
		'{ACT_DECRYPT, 32'h0000_0001, 32'h8000_0000},
		'{ACT_DECRYPT, 32'h41ea_3a0a, 32'h94ba_a940},
		'{ACT_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef}
	};

	always #5ns clk = ~clk;

	tea_block_cipher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tea_block_cipher_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Words biased toward the extremes, single set bits and single clear bits.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'h1 << $urandom_range(0, 31);
			3: return ~(32'h1 << $urandom_range(0, 31));
			default: return $urandom();
		endcase
	endfunction

	function automatic req_t pick_block();
		req_t blk;
		blk.action = $urandom_range(0, 1) ? ACT_DECRYPT : ACT_ENCRYPT;
		blk.block_first_word = pick_word();
		blk.block_second_word = pick_word();
		return blk;
	endfunction

	// Called at a rising edge; returns at the edge that takes the word, valid still high, or after an idle, valid low.
	task automatic send_block(input req_t blk);
		req <= blk;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] data);
		cfg_index <= index;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Unmapped writes go last, so a decoder that aliases them would corrupt the key.
	task automatic program_key(input key_t k);
		write_reg(REG_KEY_WORD0, k.key_word0);
		write_reg(REG_KEY_WORD1, k.key_word1);
		write_reg(REG_KEY_WORD2, k.key_word2);
		write_reg(REG_KEY_WORD3, k.key_word3);
		write_reg(UNMAPPED_INDEX_LOW, $urandom());
		write_reg(UNMAPPED_INDEX_TOP, $urandom());
		write_reg(CFG_INDEX_W'($urandom_range(4, 255)), $urandom());
		cfg_valid <= 1'b0;
	endtask

	// Response side: stall bursts, sometimes long stretches of steady ready.
	initial begin
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(0, 4) == 0 ? 40 : $urandom_range(1, 10)) @(posedge clk);
		end
	end

	initial begin
		key_t k;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key of all zeros, then all ones
		foreach (corner_blocks[i])
			send_block(corner_blocks[i]);
		wait_for_drain();
		program_key('1);
		foreach (corner_blocks[i])
			send_block(corner_blocks[i]);
		wait_for_drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			k.key_word0 = pick_word();
			k.key_word1 = pick_word();
			k.key_word2 = pick_word();
			k.key_word3 = pick_word();
			program_key(k);
			// hold both sides steady through the last phase
			if (phase == RANDOM_PHASES - 1)
				quiet = 1'b1;
			repeat (BLOCKS_PER_PHASE)
				send_block(pick_block());
			wait_for_drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tea_block_cipher verification clean");
		end else begin
			$display("tea_block_cipher verification failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("tea_block_cipher verification failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+design
design/tea_pkg.sv
design/tea_half_round.sv
design/tea_out_queue.sv
design/tea_block_cipher.sv
verif/tea_block_cipher_checker.sv
verif/tea_block_cipher_tb.sv
